/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Plain property, sampled on the rising clock edge, off while in reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/slab_pkg.sv */
// ----------------------------------------------------------------------------
// slab_pkg
// Types, constants and helpers shared by the sound level alarm bar graph.
// ----------------------------------------------------------------------------
`default_nettype none

package slab_pkg;

  localparam int NUM_LEDS = 8;
  localparam int LIT_W    = 4;
  localparam int LED_W    = 8;

  localparam logic [7:0]  MID_LEVEL_RST = 8'd96;
  localparam logic [15:0] HOLD_MS_RST   = 16'd2000;
  localparam logic [31:0] TICK_INC_RST  = 32'h0831_26E9;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_MID_LEVEL = 2'd0;
  localparam logic [1:0] CFG_HOLD_MS   = 2'd1;
  localparam logic [1:0] CFG_TICK_INC  = 2'd2;

  // raw action codes on the input word
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_SAMPLE,
    KIND_REFRESH,
    KIND_IDLE
  } kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] mic_sample;
    logic [7:0] threshold_sample;
  } in_word_t;

  typedef struct packed {
    logic [LED_W-1:0] led_pattern;
    logic [LIT_W-1:0] lit_count;
    logic             alarm_active;
    logic             alarm_notice;
  } out_word_t;

  // decoded word held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] mic;
    logic       trigger;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0]  mid_level;
    logic [15:0] hold_ms;
    logic [31:0] tick_increment;
  } cfg_t;

  // active-low bar: bit i cleared when LED i is lit
  function automatic logic [LED_W-1:0] bar_pattern(input logic [LIT_W-1:0] lit);
    logic [LED_W-1:0] p;
    p = '1;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (LIT_W'(i) < lit) begin
        p[i] = 1'b0;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/sound_level_alarm_bargraph.sv */
// An accepted word goes through the front register, a queue slot and the result register.
// Throughput: one word per cycle when not stalled, set by the back end timer/alarm update.
// The four-entry queue lets the front keep taking words while the result register is stalled.
// Reset (rst_n low, synchronous) clears the queue, the timer and the alarm, sets the blink
// phase to all lit and loads mid_level 96, hold_ms 2000 and tick_increment 0x083126E9.
// ----------------------------------------------------------------------------
// sound_level_alarm_bargraph
// Sound level alarm with millisecond timer and active-low LED bar output.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_level_alarm_bargraph
  import slab_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // Configuration bank. Only to be written while the block is idle (the block does not
  // enforce this), so the back end reads it directly with no shadowing.
  cfg_t    cfg_r, cfg_nxt;

  // front to queue
  logic    push;
  q_word_t push_word;
  // queue to back
  logic    pop;
  q_word_t pop_word;
  q_stat_t q_stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MID_LEVEL: cfg_nxt.mid_level      = cfg_wdata[7:0];
        CFG_HOLD_MS:   cfg_nxt.hold_ms        = cfg_wdata[15:0];
        CFG_TICK_INC:  cfg_nxt.tick_increment = cfg_wdata;
        default:       cfg_nxt = cfg_r;   // unmapped index: no register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_level      <= MID_LEVEL_RST;
      cfg_r.hold_ms        <= HOLD_MS_RST;
      cfg_r.tick_increment <= TICK_INC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: takes the word, decodes the action and does the mic/threshold compare.
  slab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  // Queue: decouples the front from result back-pressure.
  slab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (q_stat)
  );

  // Back: timer accumulation, alarm hold, blink and bar graph, result register.
  slab_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_word    (pop_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* rtl/slab_front.sv */
// ----------------------------------------------------------------------------
// slab_front
// Accepts input words, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module slab_front
  import slab_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output q_word_t       push_word
);

  logic    vld_r, vld_nxt;
  q_word_t word_r, word_nxt;
  logic    take;
  kind_t   kind;

  always_comb begin
    unique case (in_word.action)
      ACT_TICK:    kind = KIND_TICK;
      ACT_SAMPLE:  kind = KIND_SAMPLE;
      ACT_REFRESH: kind = KIND_REFRESH;
      default:     kind = KIND_IDLE;
    endcase
  end

  assign push     = vld_r && !q_stat.full;
  assign in_stall = vld_r && q_stat.full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt  = vld_r;
    word_nxt = word_r;
    if (take) begin
      vld_nxt          = 1'b1;
      word_nxt.kind    = kind;
      word_nxt.mic     = in_word.mic_sample;
      word_nxt.trigger = in_word.mic_sample > in_word.threshold_sample;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    word_r <= word_nxt;
  end

  assign push_word = word_r;

endmodule

`default_nettype wire

/* rtl/slab_queue.sv */
// ----------------------------------------------------------------------------
// slab_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slab_queue
  import slab_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_word_t push_word,
  input  wire logic    pop,
  output q_word_t      pop_word,
  output q_stat_t      stat
);

  q_word_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

  assign pop_word   = slot_r[rd_ptr_r];
  assign stat.full  = count_r == Q_CNT_W'(Q_DEPTH);
  assign stat.empty = count_r == '0;

  `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !stat.full)
  `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !stat.empty)
  `ASSERT_PROP(a_count_up, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
  `ASSERT_PROP(a_count_dn, clk, rst_n, (pop && !push) |=> (count_r == $past(count_r) - 1'b1))

endmodule

`default_nettype wire

/* rtl/slab_back.sv */
// ----------------------------------------------------------------------------
// slab_back
// Timer, alarm and bar logic; one queued word per cycle to the result register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slab_back
  import slab_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire q_stat_t q_stat,
  input  wire q_word_t q_word,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_word_t    out_word
);

  logic [23:0] frac_r, frac_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic        alarm_r, alarm_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] deadline_r, deadline_nxt;   // alarm start plus hold time
  logic [7:0]  last_mic_r, last_mic_nxt;
  logic        blink_r, blink_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic [31:0]      sum;
  logic [7:0]       dev;
  logic [LIT_W-1:0] lit;
  logic             notice;
  logic [LED_W-1:0] pattern;

  assign pop = !q_stat.empty && (!out_vld_r || !out_stall);

  always_comb begin
    frac_nxt     = frac_r;
    ms_nxt       = ms_r;
    alarm_nxt    = alarm_r;
    start_nxt    = start_r;
    last_mic_nxt = last_mic_r;
    blink_nxt    = blink_r;
    lit          = '0;
    notice       = 1'b0;
    pattern      = '1;
    sum          = {8'd0, frac_r} + cfg.tick_increment;
    dev          = (last_mic_r >= cfg.mid_level) ? last_mic_r - cfg.mid_level
                                                 : cfg.mid_level - last_mic_r;
    if (pop) begin
      unique case (q_word.kind)
        KIND_TICK: begin
          frac_nxt = sum[23:0];
          ms_nxt   = ms_r + {24'd0, sum[31:24]};
          if (alarm_r && (ms_nxt > deadline_r)) begin
            alarm_nxt = 1'b0;
          end
        end
        KIND_SAMPLE: begin
          last_mic_nxt = q_word.mic;
          if (q_word.trigger) begin
            alarm_nxt = 1'b1;
            start_nxt = ms_r;
          end
        end
        KIND_REFRESH: begin
          if (alarm_r) begin
            blink_nxt = !blink_r;
            lit       = blink_nxt ? LIT_W'(NUM_LEDS) : '0;
            notice    = 1'b1;
          end else if (dev[7:3] > 5'(NUM_LEDS)) begin
            lit = LIT_W'(NUM_LEDS);
          end else begin
            lit = LIT_W'(dev[7:3]);
          end
          pattern = bar_pattern(lit);
        end
        KIND_IDLE: begin
        end
        default: begin
        end
      endcase
    end
    deadline_nxt = start_nxt + {16'd0, cfg.hold_ms};
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_word_nxt = out_word_r;
    if (pop) begin
      out_vld_nxt               = 1'b1;
      out_word_nxt.led_pattern  = pattern;
      out_word_nxt.lit_count    = lit;
      out_word_nxt.alarm_active = alarm_nxt;
      out_word_nxt.alarm_notice = notice;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r     <= '0;
      ms_r       <= '0;
      alarm_r    <= 1'b0;
      start_r    <= '0;
      deadline_r <= {16'd0, HOLD_MS_RST};
      last_mic_r <= '0;
      blink_r    <= 1'b1;
      out_vld_r  <= 1'b0;
    end else begin
      frac_r     <= frac_nxt;
      ms_r       <= ms_nxt;
      alarm_r    <= alarm_nxt;
      start_r    <= start_nxt;
      deadline_r <= deadline_nxt;
      last_mic_r <= last_mic_nxt;
      blink_r    <= blink_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  `ASSERT_IMPLY(a_notice_in_alarm, clk, rst_n, out_vld_r && out_word_r.alarm_notice, out_word_r.alarm_active)
  `ASSERT_IMPLY(a_bar_count, clk, rst_n, out_vld_r, $countones(~out_word_r.led_pattern) == out_word_r.lit_count)
  `ASSERT_IMPLY(a_alarm_drop, clk, rst_n, $fell(alarm_r) && $past(rst_n), $past(pop && (q_word.kind == KIND_TICK)))
  `ASSERT_IMPLY(a_alarm_rise, clk, rst_n, $rose(alarm_r) && $past(rst_n), $past(pop && (q_word.kind == KIND_SAMPLE) && q_word.trigger))

endmodule

`default_nettype wire
